// ===== rtl/lzwc_pkg.sv =====
package lzwc_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int CODE_W       = 12;
    localparam int SYM_W        = 8;
    localparam int WID_W        = 4;
    localparam int EPOCH_W      = 8;
    // hash table has twice the dictionary size to keep probe chains short
    localparam int HASH_W       = $clog2(DICT_ENTRIES) + 1;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [CODE_W-1:0] CLEAR_CODE = 12'd256;
    localparam logic [CODE_W-1:0] END_CODE   = 12'd257;
    localparam logic [CODE_W-1:0] FIRST_FREE = 12'd258;
    localparam logic [CODE_W-1:0] CLEAR_AT   = CODE_W'(DICT_ENTRIES - 2);
    localparam logic [WID_W-1:0]  MIN_WIDTH  = 4'd9;

    typedef struct packed {
        logic             first;
        logic             last;
        logic [SYM_W-1:0] sym;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [WID_W-1:0]  width;
        logic              fin;   // end of item marker, no code
        logic              last;  // end of stream (with fin)
    } t_cmd;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [CODE_W-1:0]  prefix;
        logic [SYM_W-1:0]   sym;
        logic [CODE_W-1:0]  code;
    } t_slot;

    function automatic logic [WID_W-1:0] width_for(input logic [CODE_W-1:0] n);
        logic [WID_W-1:0] w;
        w = 4'd9;
        if (n >= 12'd512)  w = 4'd10;
        if (n >= 12'd1024) w = 4'd11;
        if (n >= 12'd2048) w = 4'd12;
        return w;
    endfunction

    function automatic logic [HASH_W-1:0] hash_of(input logic [CODE_W-1:0] cur,
                                                  input logic [SYM_W-1:0] sym);
        return (HASH_W'(sym) << (HASH_W - SYM_W)) ^ HASH_W'(cur);
    endfunction

endpackage

// ===== rtl/lzw_compressor_variable_width.sv =====
// Channel  | Dir | tdata            | tlast   | tuser
// s_axis   | in  | [7:0] data_byte  | last_in | -
// m_axis   | out | [7:0] out_byte   | run_end | [0] stream_end
//
// Steps: per source byte on a first-probe hit, pop, table read, compare,
// item end; each extra hash probe adds a read and compare, each emitted code
// a packer hand-off and one shift per packed byte. The single-port hash
// table read loop and the serial bit packer set this pacing.
// Reset: sweep of all 8192 hash table entries, repeated on every 255th
// dictionary clear; no source byte is processed then (input queue fills).
// Stalls: a 4-beat input queue and an output register decouple both sides.
module lzw_compressor_variable_width (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_end
    output logic [0:0]  m_axis_tuser    // [0] stream_end
);
    import lzwc_pkg::*;

    logic   w_head_valid, w_pop, w_cmd_valid, w_cmd_ready;
    t_item  w_head;
    t_cmd   w_cmd;

    // front: accept beats, tag stream start, queue
    lzwc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sym        (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // back: dictionary search and code sequencing
    lzwc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_ready  (w_cmd_ready)
    );

    // MSB-first bit packing, one byte held back to mark run end
    lzwc_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_ready  (w_cmd_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_run_end    (m_axis_tlast),
        .o_stream_end (m_axis_tuser[0])
    );

    a_se_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("stream end without run end");

    a_code_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_valid && !w_cmd.fin |-> w_cmd.width >= MIN_WIDTH && w_cmd.width <= 4'd12)
        else $error("code width out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// ===== rtl/lzwc_front.sv =====
module lzwc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_sym,
    input  logic                  i_last,
    output logic                  o_head_valid,
    output lzwc_pkg::t_item       o_head,
    input  logic                  i_pop
);
    import lzwc_pkg::*;

    t_item                r_q [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [FIFO_AW:0]     r_cnt;
    logic                 r_first;   // next beat opens a stream

    logic w_push, w_pop;

    assign o_ready      = (r_cnt < (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_first <= 1'b1;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= '{first: r_first, last: i_last, sym: i_sym};
                r_wp      <= r_wp + 1'b1;
                r_first   <= i_last;
            end
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(w_push) - (FIFO_AW+1)'(w_pop);
        end
    end

endmodule

// ===== rtl/lzwc_engine.sv =====
module lzwc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  lzwc_pkg::t_item   i_head,
    output logic              o_pop,
    output logic              o_cmd_valid,
    output lzwc_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_ready
);
    import lzwc_pkg::*;

    typedef enum logic [3:0] {
        E_SWEEP, E_IDLE, E_CLR, E_RD, E_CMP, E_MISS, E_FLUSH, E_ENDC, E_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [CODE_W-1:0]   r_cur, n_cur;
    logic [CODE_W-1:0]   r_nfc, n_nfc;
    logic [WID_W-1:0]    r_width, n_width;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [HASH_W-1:0]   r_addr, n_addr;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic                r_last, n_last;
    logic                r_first, n_first;
    logic                r_busy, n_busy;

    t_slot               r_mem [1 << HASH_W];
    t_slot               r_rd;
    logic                w_we;
    t_slot               w_wd;
    logic [CODE_W-1:0]   w_nfc_inc;

    assign w_nfc_inc = r_nfc + 12'd1;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_addr] <= w_wd;
        r_rd <= r_mem[r_addr];
    end

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_nfc   = r_nfc;
        n_width = r_width;
        n_epoch = r_epoch;
        n_addr  = r_addr;
        n_sym   = r_sym;
        n_last  = r_last;
        n_first = r_first;
        n_busy  = r_busy;
        o_pop       = 1'b0;
        o_cmd_valid = 1'b0;
        o_cmd       = '{code: r_cur, width: r_width, fin: 1'b0, last: 1'b0};
        w_we = 1'b0;
        w_wd = '{tag: r_epoch, prefix: r_cur, sym: r_sym, code: r_nfc};
        case (r_state)
            E_SWEEP: begin
                w_we   = 1'b1;
                w_wd   = '0;
                n_addr = r_addr + 1'b1;
                if (r_addr == '1) begin
                    n_epoch = EPOCH_W'(1);
                    if (!r_busy) begin
                        n_state = E_IDLE;
                    end else if (r_first) begin
                        n_state = E_FLUSH;
                    end else begin
                        n_state = E_RD;
                        n_addr  = hash_of(r_cur, r_sym);
                    end
                end
            end
            E_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_busy  = 1'b1;
                    n_sym   = i_head.sym;
                    n_last  = i_head.last;
                    n_first = i_head.first;
                    if (i_head.first) begin
                        n_cur = CODE_W'(i_head.sym);
                        if (i_head.last && r_nfc == CLEAR_AT) n_state = E_CLR;
                        else if (i_head.last)                n_state = E_FLUSH;
                        else                                 n_state = E_FIN;
                    end else if (r_nfc == CLEAR_AT) begin
                        n_state = E_CLR;
                    end else begin
                        n_state = E_RD;
                        n_addr  = hash_of(r_cur, i_head.sym);
                    end
                end
            end
            E_CLR: begin
                o_cmd_valid = 1'b1;
                o_cmd.code  = CLEAR_CODE;
                if (i_cmd_ready) begin
                    n_nfc   = FIRST_FREE;
                    n_width = MIN_WIDTH;
                    n_epoch = r_epoch + 1'b1;
                    if (r_epoch == '1) begin
                        n_state = E_SWEEP;
                        n_addr  = '0;
                    end else if (r_first) begin
                        n_state = E_FLUSH;
                    end else begin
                        n_state = E_RD;
                        n_addr  = hash_of(r_cur, r_sym);
                    end
                end
            end
            E_RD: begin
                n_state = E_CMP;
            end
            E_CMP: begin
                if (r_rd.tag == r_epoch) begin
                    if (r_rd.prefix == r_cur && r_rd.sym == r_sym) begin
                        n_cur   = r_rd.code;
                        n_state = r_last ? E_FLUSH : E_FIN;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = E_RD;
                    end
                end else begin
                    w_we    = 1'b1;
                    n_state = E_MISS;
                end
            end
            E_MISS: begin
                o_cmd_valid = 1'b1;
                if (i_cmd_ready) begin
                    n_cur   = CODE_W'(r_sym);
                    n_nfc   = w_nfc_inc;
                    n_width = width_for(w_nfc_inc);
                    n_state = r_last ? E_FLUSH : E_FIN;
                end
            end
            E_FLUSH: begin
                o_cmd_valid = 1'b1;
                if (i_cmd_ready) begin
                    n_nfc   = w_nfc_inc;
                    n_width = width_for(w_nfc_inc);
                    n_state = E_ENDC;
                end
            end
            E_ENDC: begin
                o_cmd_valid = 1'b1;
                o_cmd.code  = END_CODE;
                if (i_cmd_ready) n_state = E_FIN;
            end
            E_FIN: begin
                o_cmd_valid = 1'b1;
                o_cmd.fin   = 1'b1;
                o_cmd.last  = r_last;
                if (i_cmd_ready) begin
                    n_busy  = 1'b0;
                    n_state = E_IDLE;
                    if (r_last) begin
                        n_cur   = '0;
                        n_nfc   = CLEAR_AT;
                        n_width = MIN_WIDTH;
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_SWEEP;
            r_cur   <= '0;
            r_nfc   <= CLEAR_AT;
            r_width <= MIN_WIDTH;
            r_epoch <= '0;
            r_addr  <= '0;
            r_busy  <= 1'b0;
            r_last  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_nfc   <= n_nfc;
            r_width <= n_width;
            r_epoch <= n_epoch;
            r_addr  <= n_addr;
            r_busy  <= n_busy;
            r_last  <= n_last;
            r_first <= n_first;
        end
        r_sym <= n_sym;
    end

endmodule

// ===== rtl/lzwc_packer.sv =====
module lzwc_packer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  lzwc_pkg::t_cmd    i_cmd,
    output logic              o_cmd_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_run_end,
    output logic              o_stream_end
);
    import lzwc_pkg::*;

    typedef enum logic [1:0] {P_IDLE, P_SHIFT, P_REL} t_state;

    t_state        r_state;
    logic [18:0]   r_acc;
    logic [4:0]    r_n;
    logic [6:0]    r_pend;
    logic [2:0]    r_cnt;
    logic [7:0]    r_hold;
    logic          r_hold_v;
    logic          r_fin, r_last;
    logic          r_out_v, r_out_re, r_out_se;
    logic [7:0]    r_out_byte;

    logic          w_move;
    logic [7:0]    w_byte;
    logic [18:0]   w_code;

    assign w_move       = !r_out_v || i_ready;
    assign w_byte       = 8'(r_acc >> (r_n - 5'd8));
    assign w_code       = 19'(i_cmd.code) & ((19'd1 << i_cmd.width) - 19'd1);
    assign o_cmd_ready  = (r_state == P_IDLE);
    assign o_valid      = r_out_v;
    assign o_byte       = r_out_byte;
    assign o_run_end    = r_out_re;
    assign o_stream_end = r_out_se;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= P_IDLE;
            r_pend   <= '0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_fin    <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            case (r_state)
                P_IDLE: begin
                    if (i_cmd_valid) begin
                        if (!i_cmd.fin) begin
                            r_acc   <= (19'(r_pend) << i_cmd.width) | w_code;
                            r_n     <= 5'(r_cnt) + 5'(i_cmd.width);
                            r_fin   <= 1'b0;
                            r_state <= P_SHIFT;
                        end else begin
                            r_last <= i_cmd.last;
                            if (i_cmd.last && r_cnt != '0) begin
                                // zero fill to the byte boundary
                                r_acc   <= 19'(r_pend) << (4'd8 - {1'b0, r_cnt});
                                r_n     <= 5'd8;
                                r_fin   <= 1'b1;
                                r_state <= P_SHIFT;
                            end else begin
                                r_state <= P_REL;
                            end
                        end
                    end
                end
                P_SHIFT: begin
                    if (r_n >= 5'd8) begin
                        if (w_move) begin
                            if (r_hold_v) begin
                                r_out_v    <= 1'b1;
                                r_out_byte <= r_hold;
                                r_out_re   <= 1'b0;
                                r_out_se   <= 1'b0;
                            end
                            r_hold   <= w_byte;
                            r_hold_v <= 1'b1;
                            r_n      <= r_n - 5'd8;
                        end
                    end else begin
                        r_pend  <= 7'(r_acc) & ((7'd1 << r_n[2:0]) - 7'd1);
                        r_cnt   <= r_n[2:0];
                        r_state <= r_fin ? P_REL : P_IDLE;
                    end
                end
                P_REL: begin
                    // held byte is the item's final beat
                    if (w_move) begin
                        if (r_hold_v) begin
                            r_out_v    <= 1'b1;
                            r_out_byte <= r_hold;
                            r_out_re   <= 1'b1;
                            r_out_se   <= r_last;
                            r_hold_v   <= 1'b0;
                        end
                        r_state <= P_IDLE;
                    end
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

endmodule
